[rtl/sphs_pkg.sv]
package sphs_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned NORM_W = 16;
  localparam int unsigned RAD_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_X  = 3'd0,
    REG_PLANE_Y  = 3'd1,
    REG_PLANE_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_RADIUS   = 3'd6
  } cfg_reg_t;

  localparam logic [NORM_W-1:0] NORMAL_Z_RESET = 16'sd16384;
  localparam logic [RAD_W-1:0]  RADIUS_RESET   = 16'd400;

  localparam logic [7:0] IN_RED   = 8'd200;
  localparam logic [7:0] IN_GREEN = 8'd200;
  localparam logic [7:0] IN_BLUE  = 8'd200;
  localparam logic [7:0] OUT_RED   = 8'd192;
  localparam logic [7:0] OUT_GREEN = 8'd57;
  localparam logic [7:0] OUT_BLUE  = 8'd43;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } segment_t;

  typedef struct packed {
    logic                      seen;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
    logic signed [COORD_W-1:0] hit_z;
    logic        [7:0]         red;
    logic        [7:0]         green;
    logic        [7:0]         blue;
  } hit_t;

endpackage

[rtl/sphs_divider.sv]
// Pipelined restoring divider: one quotient bit per stage, rounded to nearest.
module sphs_divider #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 32,
  parameter int unsigned TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [TW-1:0] tag_out
);

  localparam int unsigned RW = DW + 1;

  logic          vld [QW+1];
  logic [NW-1:0] num_s [QW+1];
  logic [RW-1:0] rem_s [QW+1];
  logic [DW-1:0] den_s [QW+1];
  logic [QW-1:0] q_s [QW+1];
  logic [TW-1:0] tag_s [QW+1];

  // Quotient fits QW bits, so the top NW-QW numerator bits form a partial
  // remainder below the divisor.
  always_comb begin
    vld[0]   = in_valid;
    num_s[0] = numer;
    rem_s[0] = RW'(numer[NW-1:QW]);
    den_s[0] = denom;
    q_s[0]   = '0;
    tag_s[0] = tag_in;
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [RW:0] sh;
    logic [RW:0] df;
    always_comb begin
      sh = {rem_s[g], num_s[g][QW-1-g]};
      df = sh - {2'b00, den_s[g]};
    end
    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else     vld[g+1] <= vld[g];
      num_s[g+1] <= num_s[g];
      den_s[g+1] <= den_s[g];
      tag_s[g+1] <= tag_s[g];
      if (!df[RW]) begin
        rem_s[g+1] <= df[RW-1:0];
        q_s[g+1]   <= {q_s[g][QW-2:0], 1'b1};
      end else begin
        rem_s[g+1] <= sh[RW-1:0];
        q_s[g+1]   <= {q_s[g][QW-2:0], 1'b0};
      end
    end
  end

  logic [RW:0] rem2;
  always_comb rem2 = {rem_s[QW], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= vld[QW];
    quot    <= q_s[QW] + QW'(rem2 >= {2'b00, den_s[QW]});
    tag_out <= tag_s[QW];
  end

endmodule

[rtl/segment_plane_hit_shader.sv]
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+----------------------------------
// segment  | start, seg (segment_t), busy   | taken when start && !busy
// result   | done, result (hit_t)           | one cycle strobe, cannot stall
// config   | cfg_we, cfg_index, cfg_data    | written when cfg_we
//
// Fully pipelined: one item per cycle, busy stays low.
// The pipeline has six front stages, the divider (one quotient bit per
// stage) and three back stages.
// rst (synchronous) clears all valid bits and loads register defaults.
// No stalls: every item that enters leaves on done.
module segment_plane_hit_shader #(
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  sphs_pkg::segment_t                seg,
  output logic                              done,
  output sphs_pkg::hit_t                    result,
  input  logic                              cfg_we,
  input  logic [sphs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sphs_pkg::COORD_W-1:0]      cfg_data
);

  localparam int unsigned CW  = sphs_pkg::COORD_W;
  localparam int unsigned NWD = sphs_pkg::NORM_W;
  localparam int unsigned DFW = CW + 1;            // coordinate difference
  localparam int unsigned PW  = DFW + NWD;         // one product term
  localparam int unsigned DTW = PW + 2;            // dot product
  localparam int unsigned QW  = CW + 1;            // |l|*t fits one diff
  localparam int unsigned NUW = DFW + DTW;         // dividend width
  localparam int unsigned SQW = 2 * DFW + 2;       // squared distance
  localparam int unsigned TW  = 3 * CW + 3 * DFW;  // carried start and l
  localparam int unsigned DLAT = QW + 1;
  localparam int unsigned ALO = (DTW + 1) / 2;     // low slice of |num|
  localparam int unsigned PLW = DFW + ALO;         // partial product

  // ---------------- configuration registers ----------------
  logic signed [CW-1:0]  plane_x, plane_y, plane_z;
  logic signed [NWD-1:0] normal_x, normal_y, normal_z;
  logic [sphs_pkg::RAD_W-1:0] radius_squared;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_x <= '0;
      plane_y <= '0;
      plane_z <= '0;
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= sphs_pkg::NORMAL_Z_RESET;
      radius_squared <= sphs_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sphs_pkg::REG_PLANE_X:  plane_x <= cfg_data;
        sphs_pkg::REG_PLANE_Y:  plane_y <= cfg_data;
        sphs_pkg::REG_PLANE_Z:  plane_z <= cfg_data;
        sphs_pkg::REG_NORMAL_X: normal_x <= cfg_data[NWD-1:0];
        sphs_pkg::REG_NORMAL_Y: normal_y <= cfg_data[NWD-1:0];
        sphs_pkg::REG_NORMAL_Z: normal_z <= cfg_data[NWD-1:0];
        sphs_pkg::REG_RADIUS:   radius_squared <= cfg_data[sphs_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: differences ----------------
  logic s1_v;
  logic signed [CW-1:0]  s1_s [3];
  logic signed [DFW-1:0] s1_l [3], s1_d [3];

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else     s1_v <= start;
    s1_s[0] <= seg.start_x[CW-1:0];
    s1_s[1] <= seg.start_y[CW-1:0];
    s1_s[2] <= seg.start_z[CW-1:0];
    s1_l[0] <= DFW'(signed'(seg.end_x[CW-1:0])) - DFW'(signed'(seg.start_x[CW-1:0]));
    s1_l[1] <= DFW'(signed'(seg.end_y[CW-1:0])) - DFW'(signed'(seg.start_y[CW-1:0]));
    s1_l[2] <= DFW'(signed'(seg.end_z[CW-1:0])) - DFW'(signed'(seg.start_z[CW-1:0]));
    s1_d[0] <= DFW'(plane_x) - DFW'(signed'(seg.start_x[CW-1:0]));
    s1_d[1] <= DFW'(plane_y) - DFW'(signed'(seg.start_y[CW-1:0]));
    s1_d[2] <= DFW'(plane_z) - DFW'(signed'(seg.start_z[CW-1:0]));
  end

  // ---------------- stage 2: products ----------------
  logic s2_v;
  logic signed [CW-1:0]  s2_s [3];
  logic signed [DFW-1:0] s2_l [3];
  logic signed [PW-1:0]  s2_pl [3], s2_pd [3];
  logic signed [NWD-1:0] nv [3];

  always_comb begin
    nv[0] = normal_x;
    nv[1] = normal_y;
    nv[2] = normal_z;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else     s2_v <= s1_v;
    for (int i = 0; i < 3; i++) begin
      s2_s[i]  <= s1_s[i];
      s2_l[i]  <= s1_l[i];
      s2_pl[i] <= PW'(s1_l[i]) * PW'(nv[i]);
      s2_pd[i] <= PW'(s1_d[i]) * PW'(nv[i]);
    end
  end

  // ---------------- stage 3: dot products ----------------
  logic s3_v;
  logic signed [CW-1:0]  s3_s [3];
  logic signed [DFW-1:0] s3_l [3];
  logic signed [DTW-1:0] s3_den, s3_num;

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else     s3_v <= s2_v;
    for (int i = 0; i < 3; i++) begin
      s3_s[i] <= s2_s[i];
      s3_l[i] <= s2_l[i];
    end
    s3_den <= DTW'(s2_pl[0]) + DTW'(s2_pl[1]) + DTW'(s2_pl[2]);
    s3_num <= DTW'(s2_pd[0]) + DTW'(s2_pd[1]) + DTW'(s2_pd[2]);
  end

  // ---------------- stage 4: classify, magnitudes ----------------
  logic s4_v, s4_hit, s4_onp;
  logic signed [CW-1:0]  s4_s [3];
  logic signed [DFW-1:0] s4_l [3];
  logic [DFW-1:0] s4_al [3];
  logic [DTW-1:0] s4_an, s4_ad;
  logic [DTW-1:0] an_c, ad_c;
  logic           hit_c;

  always_comb begin
    an_c = s3_num[DTW-1] ? DTW'(-s3_num) : DTW'(s3_num);
    ad_c = s3_den[DTW-1] ? DTW'(-s3_den) : DTW'(s3_den);
    hit_c = (s3_den != '0) &&
            ((s3_num == '0) || ((s3_num[DTW-1] == s3_den[DTW-1]) && (an_c <= ad_c)));
  end

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else     s4_v <= s3_v;
    s4_hit <= hit_c;
    s4_onp <= (s3_num == '0);
    s4_an  <= an_c;
    s4_ad  <= ad_c;
    for (int i = 0; i < 3; i++) begin
      s4_s[i]  <= s3_s[i];
      s4_l[i]  <= s3_l[i];
      s4_al[i] <= s3_l[i][DFW-1] ? DFW'(-s3_l[i]) : DFW'(s3_l[i]);
    end
  end

  // ---------------- stage 5: |l| times each half of |num| ----------------
  logic s5_v, s5_hit, s5_onp;
  logic signed [CW-1:0]  s5_s [3];
  logic signed [DFW-1:0] s5_l [3];
  logic [PLW-1:0] s5_plo [3], s5_phi [3];
  logic [DTW-1:0] s5_ad;

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else     s5_v <= s4_v;
    s5_hit <= s4_hit;
    s5_onp <= s4_onp;
    s5_ad  <= s4_ad;
    for (int i = 0; i < 3; i++) begin
      s5_s[i]   <= s4_s[i];
      s5_l[i]   <= s4_l[i];
      s5_plo[i] <= PLW'(s4_al[i]) * PLW'(s4_an[ALO-1:0]);
      s5_phi[i] <= PLW'(s4_al[i]) * PLW'(s4_an[DTW-1:ALO]);
    end
  end

  // ---------------- stage 6: combine partial products ----------------
  logic s6_v, s6_hit, s6_onp;
  logic signed [CW-1:0]  s6_s [3];
  logic signed [DFW-1:0] s6_l [3];
  logic [NUW-1:0] s6_prod [3];
  logic [DTW-1:0] s6_ad;

  always_ff @(posedge clk) begin
    if (rst) s6_v <= 1'b0;
    else     s6_v <= s5_v;
    s6_hit <= s5_hit;
    s6_onp <= s5_onp;
    s6_ad  <= s5_ad;
    for (int i = 0; i < 3; i++) begin
      s6_s[i]    <= s5_s[i];
      s6_l[i]    <= s5_l[i];
      s6_prod[i] <= NUW'(s5_plo[i]) + (NUW'(s5_phi[i]) << ALO);
    end
  end

  // ---------------- stages 7..: three dividers ----------------
  logic [QW-1:0] dq [3];
  logic          dv [3];
  logic [TW+2-1:0] dtag [3];
  logic [TW+2-1:0] tag_in;

  assign tag_in = {s6_hit, s6_onp, s6_s[0], s6_s[1], s6_s[2],
                   s6_l[0], s6_l[1], s6_l[2]};

  for (genvar a = 0; a < 3; a++) begin : g_div
    sphs_divider #(.NW(NUW), .DW(DTW), .QW(QW), .TW(TW + 2)) u_div (
      .clk      (clk),
      .rst      (rst),
      .in_valid (s6_v),
      .numer    (s6_prod[a]),
      .denom    (s6_ad),
      .tag_in   (tag_in),
      .out_valid(dv[a]),
      .quot     (dq[a]),
      .tag_out  (dtag[a])
    );
  end

  logic d_hit, d_onp;
  logic signed [CW-1:0]  d_s [3];
  logic signed [DFW-1:0] d_l [3];
  assign {d_hit, d_onp, d_s[0], d_s[1], d_s[2], d_l[0], d_l[1], d_l[2]} = dtag[0];

  // ---------------- hit point ----------------
  logic h_v, h_hit;
  logic signed [CW-1:0] h_p [3];

  always_ff @(posedge clk) begin
    if (rst) h_v <= 1'b0;
    else     h_v <= dv[0];
    h_hit <= d_hit;
    for (int i = 0; i < 3; i++) begin
      if (d_onp || !d_hit) h_p[i] <= d_s[i];
      else if (d_l[i][DFW-1]) h_p[i] <= d_s[i] - CW'(dq[i]);
      else h_p[i] <= d_s[i] + CW'(dq[i]);
    end
  end

  // ---------------- distance squares ----------------
  logic q_v, q_hit;
  logic signed [CW-1:0] q_p [3];
  logic [SQW-1:0] q_sq [3];
  logic signed [DFW-1:0] dd [3];
  logic signed [2*DFW-1:0] sq_c [3];

  always_comb begin
    dd[0] = DFW'(h_p[0]) - DFW'(plane_x);
    dd[1] = DFW'(h_p[1]) - DFW'(plane_y);
    dd[2] = DFW'(h_p[2]) - DFW'(plane_z);
    for (int i = 0; i < 3; i++) sq_c[i] = dd[i] * dd[i];
  end

  always_ff @(posedge clk) begin
    if (rst) q_v <= 1'b0;
    else     q_v <= h_v;
    q_hit <= h_hit;
    for (int i = 0; i < 3; i++) begin
      q_p[i]  <= h_p[i];
      q_sq[i] <= SQW'(sq_c[i]);
    end
  end

  // ---------------- sum, compare, output register ----------------
  logic [SQW-1:0] dist_sq, thr;
  logic inside_c;

  always_comb begin
    dist_sq = q_sq[0] + q_sq[1] + q_sq[2];
    thr  = SQW'(radius_squared) << (2 * FRAC_BITS);
    inside_c = dist_sq < thr;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= q_v;
    result.seen <= q_hit;
    result.hit_x <= q_hit ? q_p[0] : '0;
    result.hit_y <= q_hit ? q_p[1] : '0;
    result.hit_z <= q_hit ? q_p[2] : '0;
    result.red   <= !q_hit ? 8'd0 : inside_c ? sphs_pkg::IN_RED   : sphs_pkg::OUT_RED;
    result.green <= !q_hit ? 8'd0 : inside_c ? sphs_pkg::IN_GREEN : sphs_pkg::OUT_GREEN;
    result.blue  <= !q_hit ? 8'd0 : inside_c ? sphs_pkg::IN_BLUE  : sphs_pkg::OUT_BLUE;
  end

  // ---------------- checks ----------------
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s6_v |-> ##(DLAT + 3) done) else $error("item lost in pipeline");
  a_dv_lockstep: assert property (@(posedge clk) disable iff (rst)
    (dv[0] == dv[1]) && (dv[1] == dv[2])) else $error("dividers out of step");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.seen) |-> (result.red == 8'd0 && result.hit_x == '0))
    else $error("miss carries data");

endmodule

[bench/tb_top.sv]
module tb_top;
  import sphs_pkg::*;

  // Allow margin on the drain beyond the block latency.
  localparam int LATENCY    = 43;
  localparam int DRAIN_WAIT = LATENCY + 20;
  localparam int STALL_MAX  = 5000;
  localparam int RAND_ITEMS = 750;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  segment_t seg = '0;
  logic done;
  hit_t result;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  segment_plane_hit_shader DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .seg(seg),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor copy of the plane registers.
  logic signed [31:0] pl_x, pl_y, pl_z;
  logic signed [15:0] nrm_x, nrm_y, nrm_z;
  logic [15:0] rad_sq;

  hit_t hits_pending[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  int send_idle_pct = 13;

  task automatic load_defaults();
    pl_x = '0; pl_y = '0; pl_z = '0;
    nrm_x = '0; nrm_y = '0; nrm_z = NORMAL_Z_RESET;
    rad_sq = RADIUS_RESET;
  endtask

  // Exact segment/plane hit: 80-bit dot products, 160-bit quotient terms.
  function automatic hit_t shade_segment(segment_t s);
    hit_t r;
    logic signed [33:0] sv[3], lv[3], dv[3], pv[3], nv[3], hv[3];
    logic signed [79:0] den, num, dist_sq, thr;
    logic [79:0] an, ad;
    logic [159:0] prod, q, rm;
    logic [33:0] al;
    int i;
    r = '0;
    sv[0] = s.start_x; sv[1] = s.start_y; sv[2] = s.start_z;
    pv[0] = pl_x; pv[1] = pl_y; pv[2] = pl_z;
    nv[0] = nrm_x; nv[1] = nrm_y; nv[2] = nrm_z;
    lv[0] = 34'(s.end_x) - sv[0];
    lv[1] = 34'(s.end_y) - sv[1];
    lv[2] = 34'(s.end_z) - sv[2];
    for (i = 0; i < 3; i++) dv[i] = pv[i] - sv[i];
    den = 80'(nv[0]) * 80'(lv[0]) + 80'(nv[1]) * 80'(lv[1]) + 80'(nv[2]) * 80'(lv[2]);
    if (den == 0) return r;
    num = 80'(nv[0]) * 80'(dv[0]) + 80'(nv[1]) * 80'(dv[1]) + 80'(nv[2]) * 80'(dv[2]);
    if (num == 0) begin
      for (i = 0; i < 3; i++) hv[i] = sv[i];
    end else begin
      if ((den < 0) != (num < 0)) return r;   // t below zero
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      if (ad < an) return r;                  // t beyond one
      for (i = 0; i < 3; i++) begin
        al = (lv[i] < 0) ? -lv[i] : lv[i];
        prod = 160'(al) * 160'(an);
        q = prod / 160'(ad);
        rm = prod % 160'(ad);
        if (2 * rm >= 160'(ad)) q = q + 1;    // nearest, ties away from zero
        hv[i] = (lv[i] < 0) ? sv[i] - 34'(q) : sv[i] + 34'(q);
      end
    end
    dist_sq = 0;
    for (i = 0; i < 3; i++) dist_sq = dist_sq + 80'(hv[i] - pv[i]) * 80'(hv[i] - pv[i]);
    thr = 80'(rad_sq) << 32;
    r.seen = 1'b1;
    r.hit_x = hv[0][31:0]; r.hit_y = hv[1][31:0]; r.hit_z = hv[2][31:0];
    if (dist_sq < thr) begin
      r.red = IN_RED; r.green = IN_GREEN; r.blue = IN_BLUE;
    end else begin
      r.red = OUT_RED; r.green = OUT_GREEN; r.blue = OUT_BLUE;
    end
    return r;
  endfunction

  // Result check at the rising edge; done cannot be held off.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (hits_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        hit_t e;
        e = hits_pending.pop_front();
        if (e.seen !== result.seen || e.hit_x !== result.hit_x ||
            e.hit_y !== result.hit_y || e.hit_z !== result.hit_z ||
            e.red !== result.red || e.green !== result.green ||
            e.blue !== result.blue) begin
          mismatches++;
          if (mismatches <= 10) $display("hit mismatch exp %p got %p", e, result);
        end
      end
    end
  end

  // Watchdog: cycles with neither an accepted item, a result, reset nor a register write.
  always @(posedge clk) begin
    if ((start && !busy) || done || rst || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX) begin
      $display("segment_plane_hit_shader verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PLANE_X:  pl_x = val;
      REG_PLANE_Y:  pl_y = val;
      REG_PLANE_Z:  pl_z = val;
      REG_NORMAL_X: nrm_x = val[15:0];
      REG_NORMAL_Y: nrm_y = val[15:0];
      REG_NORMAL_Z: nrm_z = val[15:0];
      REG_RADIUS:   rad_sq = val[15:0];
      default: ;
    endcase
  endtask

  // Drive one item from a falling edge; held until taken.
  task automatic send_segment(segment_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    seg <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    hits_pending.push_back(shade_segment(s));
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (hits_pending.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(131072)) - 65536);
      default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  // A segment that crosses the plane most of the time: endpoints about p +/- n.
  function automatic segment_t rand_segment();
    segment_t s;
    logic signed [31:0] ox, oy, oz, k;
    if ($urandom_range(99) < 30) begin
      s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
           rand_coord()};
      return s;
    end
    ox = $signed($urandom_range(2_000_000)) - 1_000_000;
    oy = $signed($urandom_range(2_000_000)) - 1_000_000;
    oz = $signed($urandom_range(2_000_000)) - 1_000_000;
    k = $urandom_range(400) + 1;
    s.start_x = pl_x + ox + nrm_x * k;
    s.start_y = pl_y + oy + nrm_y * k;
    s.start_z = pl_z + oz + nrm_z * k;
    k = -$signed($urandom_range(400));
    s.end_x = pl_x - ox + nrm_x * k + $signed($urandom_range(64)) - 32;
    s.end_y = pl_y - oy + nrm_y * k + $signed($urandom_range(64)) - 32;
    s.end_z = pl_z - oz + nrm_z * k;
    return s;
  endfunction

  // Directed table: expected typed where obvious, else predicted.
  typedef struct {
    segment_t s;
    bit       typed;
    hit_t     e;
  } vec_t;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [31:0] MINC = 32'h8000_0000;

  initial begin
    vec_t tbl[$];
    hit_t chk;
    int i, ph;
    load_defaults();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // default plane z=0, normal +z, radius 20
    tbl.push_back('{'{0, 0, ONE, 0, 0, -ONE}, 1, '{1'b1, 0, 0, 0, IN_RED, IN_GREEN, IN_BLUE}});
    tbl.push_back('{'{0, 0, ONE, 0, 0, 2 * ONE}, 1, '0});        // t negative
    tbl.push_back('{'{0, 0, -ONE, 0, 0, -2 * ONE}, 1, '0});
    tbl.push_back('{'{0, 0, 3 * ONE, 0, 0, ONE}, 1, '0});        // t beyond one
    tbl.push_back('{'{0, 0, ONE, ONE, 0, ONE}, 1, '0});          // parallel
    tbl.push_back('{'{0, 0, 0, ONE, 0, 0}, 1, '0});              // parallel in plane
    tbl.push_back('{'{5 * ONE, 0, 0, 0, 0, ONE}, 1,
                    '{1'b1, 5 * ONE, 0, 0, IN_RED, IN_GREEN, IN_BLUE}}); // start on plane
    tbl.push_back('{'{30 * ONE, 0, 0, 30 * ONE, 0, -ONE}, 1,
                    '{1'b1, 30 * ONE, 0, 0, OUT_RED, OUT_GREEN, OUT_BLUE}}); // on plane, outside
    tbl.push_back('{'{MAXC, MAXC, MAXC, MINC, MINC, MINC}, 0, '0});
    tbl.push_back('{'{MINC, MINC, MINC, MAXC, MAXC, MAXC}, 0, '0});
    tbl.push_back('{'{MAXC, MINC, MAXC, MINC, MAXC, MINC}, 0, '0});
    tbl.push_back('{'{0, 0, MAXC, 0, 0, MINC}, 0, '0});
    tbl.push_back('{'{ONE, 3, 7, -ONE, -5, -3}, 0, '0});         // rounding ties
    tbl.push_back('{'{32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF, 0, -1}, 0, '0});
    tbl.push_back('{'{19 * ONE, 0, ONE, 21 * ONE, 0, -ONE}, 0, '0});
    tbl.push_back('{'{20 * ONE, 0, ONE, 20 * ONE, 0, -ONE}, 0, '0}); // radius edge
    for (i = 0; i < tbl.size(); i++) begin
      send_segment(tbl[i].s);
      if (tbl[i].typed) begin
        chk = hits_pending[$];
        if (chk !== tbl[i].e) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d exp %p pred %p", i, tbl[i].e, chk);
        end
      end
    end
    drain();

    // register extremes, then random phases with changing idle mix
    write_reg(REG_PLANE_X, MAXC); write_reg(REG_PLANE_Y, MINC);
    write_reg(REG_PLANE_Z, 0);
    write_reg(REG_NORMAL_X, 32'h0000_7FFF); write_reg(REG_NORMAL_Y, 32'h0000_8000);
    write_reg(REG_NORMAL_Z, 32'h0000_FFFF); write_reg(REG_RADIUS, 32'h0000_FFFF);
    for (i = 0; i < 8; i++) send_segment(rand_segment());
    drain();
    write_reg(REG_RADIUS, 0);
    for (i = 0; i < 8; i++) send_segment(rand_segment());
    drain();

    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 83 : 0;
      write_reg(REG_PLANE_X, rand_coord()); write_reg(REG_PLANE_Y, rand_coord());
      write_reg(REG_PLANE_Z, rand_coord());
      write_reg(REG_NORMAL_X, {16'h0, 16'($signed($urandom_range(32768)) - 16384)});
      write_reg(REG_NORMAL_Y, {16'h0, 16'($signed($urandom_range(32768)) - 16384)});
      write_reg(REG_NORMAL_Z, {16'h0, 16'($urandom)});
      write_reg(REG_RADIUS, $urandom_range(65535));
      for (i = 0; i < RAND_ITEMS / 3; i++) begin
        send_segment(rand_segment());
        if (i == 100) begin
          // hold off until the pipe is empty
          start <= 1'b0;
          while (hits_pending.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    if (mismatches == 0 && hits_pending.size() == 0) begin
      $display("segment_plane_hit_shader verification clean");
    end else begin
      $display("segment_plane_hit_shader verification failed");
    end
    $finish;
  end
endmodule

[segment_plane_hit_shader.f]
rtl/sphs_pkg.sv
rtl/sphs_divider.sv
rtl/segment_plane_hit_shader.sv
bench/tb_top.sv
